FILE: hw/rtl/sws_pkg.sv
// Shared types, codes and defaults of the segment waveform sequencer.
package sws_pkg;

	localparam int MAX_SEGMENTS_DEF  = 8;
	localparam int COUNTER_STEPS_DEF = 256;

	localparam int CMD_W    = 2;
	localparam int IDX_W    = 3;
	localparam int DUR_W    = 8;
	localparam int LEN_W    = 4;
	localparam int SEGNUM_W = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK   = 2'd0,
		CMD_WRITE  = 2'd1,
		CMD_COMMIT = 2'd2
	} cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [IDX_W-1:0] entry_index;
		logic             entry_level;
		logic [DUR_W-1:0] entry_duration;
		logic [LEN_W-1:0] commit_length;
	} item_t;

	typedef struct packed {
		logic                line_level;
		logic                segment_start;
		logic                update_applied;
		logic [SEGNUM_W-1:0] segment_number;
	} result_t;

	typedef struct packed {
		logic             level;
		logic [DUR_W-1:0] duration;
	} entry_t;

endpackage

FILE: hw/rtl/sws_table.sv
// Staged and active segment tables with whole-table commit and one read port.
module sws_table
	import sws_pkg::*;
#(
	parameter int DEPTH   = 8,
	parameter int RD_IDXW = 3
) (
	input  logic               clk,
	input  logic               wr_en,
	input  logic [IDX_W-1:0]   wr_idx,
	input  entry_t             wr_entry,
	input  logic               swap,
	input  logic               rd_staged,
	input  logic [RD_IDXW-1:0] rd_idx,
	output entry_t             rd_entry
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	entry_t staged_q [DEPTH];
	entry_t active_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en && (int'(wr_idx) < DEPTH)) begin
			staged_q[wr_idx[AW-1:0]] <= wr_entry;
		end
		if (swap) begin
			for (int i = 0; i < DEPTH; i++) begin
				active_q[i] <= staged_q[i];
			end
		end
	end

	always_comb begin
		rd_entry = '0;
		if (int'(rd_idx) < DEPTH) begin
			rd_entry = rd_staged ? staged_q[rd_idx[AW-1:0]] : active_q[rd_idx[AW-1:0]];
		end
	end

endmodule

FILE: hw/rtl/segment_waveform_sequencer_top.sv
// Top level of the segment waveform sequencer: command decode, playback state, result register.
// Each beat on the item channel is one command: a timer tick, a staged entry write or a commit.
// One item is taken every clock cycle while item_ready is high; its result is registered, and
// item_ready drops only while the result register holds a result the consumer has not taken.
// A commit of nonzero length arms a swap of the staged table into the active table at the next
// counter wrap, after which playback restarts at entry 0. Each segment lasts duration+1 ticks.
module segment_waveform_sequencer_top
	import sws_pkg::*;
#(
	parameter int MAX_SEGMENTS  = MAX_SEGMENTS_DEF,
	parameter int COUNTER_STEPS = COUNTER_STEPS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	localparam int LEN_CAP = (1 << LEN_W) - 1;
	localparam int IDX_CAP = 1 << IDX_W;
	localparam int LMAX    = (MAX_SEGMENTS < LEN_CAP) ? MAX_SEGMENTS : LEN_CAP;
	localparam int TD      = (MAX_SEGMENTS < IDX_CAP) ? MAX_SEGMENTS : IDX_CAP;
	localparam int LW      = $clog2(LMAX + 1);
	localparam int PW      = (LMAX > 1) ? $clog2(LMAX) : 1;
	localparam int CW      = $clog2(COUNTER_STEPS);
	localparam logic [CW-1:0] CNT_TOP = CW'(COUNTER_STEPS - 1);

	logic [CW-1:0] cnt_q;
	logic [LW-1:0] act_len_q;
	logic [LW-1:0] pend_len_q;
	logic [PW-1:0] play_idx_q;
	logic          swap_q;
	logic          playing_q;
	logic          level_q;
	logic          result_valid_q;
	result_t       result_q;

	logic          accept;
	logic          wrap;
	logic [LW-1:0] eff_len;
	logic [PW-1:0] eff_idx0;
	logic [PW-1:0] eff_idx;
	logic [PW:0]   nxt_idx_full;
	logic [PW-1:0] nxt_idx;
	logic [CW-1:0] dur_sat;
	logic [CW-1:0] reload;
	entry_t        rd_entry;
	entry_t        wr_entry;
	logic          tbl_wr;
	logic          tbl_swap;
	logic [LEN_W-1:0] len_clamp;

	logic [CW-1:0] cnt_d;
	logic [LW-1:0] act_len_d;
	logic [LW-1:0] pend_len_d;
	logic [PW-1:0] play_idx_d;
	logic          swap_d;
	logic          playing_d;
	logic          level_d;
	logic          started;
	logic          applied;
	logic [LW-1:0] cur_seg;
	result_t       result_d;

	assign accept     = item_valid && item_ready;
	assign item_ready = !result_valid_q || result_ready;
	assign wrap       = (cnt_q == CNT_TOP);

	assign eff_len      = swap_q ? pend_len_q : act_len_q;
	assign eff_idx0     = swap_q ? '0 : play_idx_q;
	assign eff_idx      = ({1'b0, eff_idx0} >= (PW + 1)'(eff_len)) ? '0 : eff_idx0;
	assign nxt_idx_full = {1'b0, eff_idx} + (PW + 1)'(1);
	assign nxt_idx      = (nxt_idx_full >= (PW + 1)'(eff_len)) ? '0 : nxt_idx_full[PW-1:0];

	assign dur_sat = (rd_entry.duration > DUR_W'(COUNTER_STEPS - 1)) ? CNT_TOP
		: CW'(rd_entry.duration);
	assign reload  = CNT_TOP - dur_sat;

	assign wr_entry.level    = item.entry_level;
	assign wr_entry.duration = item.entry_duration;
	assign tbl_wr   = accept && (item.cmd == CMD_WRITE);
	assign tbl_swap = accept && (item.cmd == CMD_TICK) && wrap && swap_q;

	assign len_clamp = (item.commit_length > LEN_W'(LMAX)) ? LEN_W'(LMAX) : item.commit_length;

	sws_table #(
		.DEPTH   (TD),
		.RD_IDXW (PW)
	) u_table (
		.clk       (clk),
		.wr_en     (tbl_wr),
		.wr_idx    (item.entry_index),
		.wr_entry  (wr_entry),
		.swap      (tbl_swap),
		.rd_staged (swap_q),
		.rd_idx    (eff_idx),
		.rd_entry  (rd_entry)
	);

	always_comb begin
		cnt_d      = cnt_q;
		act_len_d  = act_len_q;
		pend_len_d = pend_len_q;
		play_idx_d = play_idx_q;
		swap_d     = swap_q;
		playing_d  = playing_q;
		level_d    = level_q;
		started    = 1'b0;
		applied    = 1'b0;
		case (item.cmd)
			CMD_WRITE: begin
			end
			CMD_COMMIT: begin
				if (item.commit_length != '0) begin
					pend_len_d = LW'(len_clamp);
					swap_d     = 1'b1;
					playing_d  = 1'b1;
				end
			end
			CMD_TICK: begin
				if (!wrap) begin
					cnt_d = cnt_q + CW'(1);
				end else begin
					cnt_d = '0;
					if (swap_q) begin
						act_len_d  = pend_len_q;
						play_idx_d = '0;
						swap_d     = 1'b0;
						applied    = 1'b1;
					end
					if (playing_q && (eff_len != '0)) begin
						level_d    = rd_entry.level;
						cnt_d      = reload;
						play_idx_d = nxt_idx;
						started    = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase

		if (act_len_d == '0) begin
			cur_seg = '0;
		end else if (play_idx_d == '0) begin
			cur_seg = act_len_d - LW'(1);
		end else begin
			cur_seg = LW'(play_idx_d) - LW'(1);
		end

		result_d.line_level     = level_d;
		result_d.segment_start  = started;
		result_d.update_applied = applied;
		result_d.segment_number = SEGNUM_W'(cur_seg);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q          <= '0;
			act_len_q      <= '0;
			pend_len_q     <= '0;
			play_idx_q     <= '0;
			swap_q         <= 1'b0;
			playing_q      <= 1'b0;
			level_q        <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q      <= cnt_d;
				act_len_q  <= act_len_d;
				pend_len_q <= pend_len_d;
				play_idx_q <= play_idx_d;
				swap_q     <= swap_d;
				playing_q  <= playing_d;
				level_q    <= level_d;
			end
			if (item_ready) begin
				result_valid_q <= item_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= result_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CNT_TOP)
		else $error("tick counter beyond its top value");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.update_applied |-> result.segment_start)
		else $error("table swap without a segment start");

	assert property (@(posedge clk) disable iff (!arst_n)
		act_len_q != '0 |-> (LW + PW)'(play_idx_q) < (LW + PW)'(act_len_q))
		else $error("play index outside the active length");

	assert property (@(posedge clk) disable iff (!arst_n) swap_q |-> playing_q)
		else $error("swap pending while playback is off");

endmodule
